FILE: sv/aus_pkg.sv
// Shared types and constants for the access unit splitter
package aus_pkg;

  localparam int LENGTH_BITS = 24;
  localparam logic [7:0] MAX_POINTS = 8'd128;
  localparam logic [4:0] SEI_HDR_LEN = 5'd30;
  localparam logic [4:0] SEI_COUNT_POS = 5'd27;
  localparam logic [15:0] SEI_SIZE_MIN = 16'd33;
  localparam logic [15:0] SEI_NEST_MIN = 16'd30;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW = 2;

  localparam logic [4:0] DROP_RST = 5'd31;
  localparam logic [4:0] DELA_RST = 5'd9;
  localparam logic [4:0] DELB_RST = 5'd24;
  localparam logic [7:0] SEI_CODE_RST = 8'd37;

  localparam logic [4:0] NAL_SLICE_LO = 5'd1;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SEI = 5'd6;
  localparam logic [4:0] NAL_SLICE_EXT = 5'd20;

  typedef enum logic [1:0] {
    REG_DROP_TYPE  = 2'd0,
    REG_DELIM_A    = 2'd1,
    REG_DELIM_B    = 2'd2,
    REG_SEI_CODE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_SC   = 3'd1,
    OP_HDR  = 3'd2,
    OP_EOS  = 3'd3,
    OP_EOS4 = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  data;
    logic [1:0]  nzero;
  } cmd_t;

  typedef struct packed {
    logic [4:0] drop_type;
    logic [4:0] delim_a;
    logic [4:0] delim_b;
    logic [7:0] sei_code;
  } cfg_t;

  typedef enum logic [3:0] {
    SP_IDLE   = 4'd0,
    SP_TYPE   = 4'd1,
    SP_SIZE   = 4'd2,
    SP_PAY0   = 4'd3,
    SP_PAY1   = 4'd4,
    SP_NEST   = 4'd5,
    SP_HDR    = 4'd6,
    SP_POINTS = 4'd7,
    SP_DONE   = 4'd8
  } sei_phase_t;

  typedef struct packed {
    sei_phase_t  phase;
    logic [15:0] accum;
    logic [15:0] nest;
    logic [15:0] paid;
    logic [4:0]  idx;
    logic [7:0]  target;
    logic [7:0]  cfirst;
    logic [7:0]  ccount;
  } sei_t;

  localparam sei_t SEI_IDLE = '{SP_IDLE, 16'd0, 16'd0, 16'd0, 5'd0, 8'd0, 8'd0, 8'd0};

endpackage

FILE: sv/aus_front.sv
// Start code detector: turns stream bytes into execution requests
module aus_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      byte_in,
  input  logic            eos,
  output logic            cmd_push,
  output aus_pkg::cmd_t   cmd
);

  logic [2:0] held_r, held_nxt;

  always_comb begin
    held_nxt = held_r;
    cmd_push = 1'b0;
    cmd.op = aus_pkg::OP_NORM;
    cmd.data = byte_in;
    cmd.nzero = 2'd0;
    if (acc) begin
      if (eos) begin
        cmd_push = 1'b1;
        cmd.op = (held_r == 3'd4) ? aus_pkg::OP_EOS4 : aus_pkg::OP_EOS;
        cmd.nzero = held_r[1:0];
        held_nxt = 3'd0;
      end else if (held_r == 3'd4) begin
        cmd_push = 1'b1;
        cmd.op = aus_pkg::OP_HDR;
        held_nxt = 3'd0;
      end else if (byte_in == 8'd0) begin
        if (held_r == 3'd3) begin
          cmd_push = 1'b1;
        end else begin
          held_nxt = held_r + 3'd1;
        end
      end else if (byte_in == 8'd1 && held_r >= 3'd2) begin
        cmd_push = 1'b1;
        cmd.op = aus_pkg::OP_SC;
        held_nxt = 3'd4;
      end else begin
        cmd_push = 1'b1;
        cmd.nzero = held_r[1:0];
        held_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 3'd0;
    end else begin
      held_r <= held_nxt;
    end
  end

endmodule

FILE: sv/aus_cmdq.sv
// Short request queue between the detector and the unit builder
module aus_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aus_pkg::cmd_t   wdata,
  input  logic            pop,
  output aus_pkg::cmd_t   rdata,
  output logic            full,
  output logic            empty
);

  aus_pkg::cmd_t mem_r [aus_pkg::CMDQ_DEPTH];
  logic [aus_pkg::CMDQ_AW-1:0] wp_r, rp_r;
  logic [aus_pkg::CMDQ_AW:0] cnt_r;

  assign full = (cnt_r == (aus_pkg::CMDQ_AW+1)'(aus_pkg::CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/aus_back.sv
// Unit builder: emits bytes and summaries, tracks counters and the offset SEI
module aus_back (
  input  logic               clk,
  input  logic               rst_n,
  input  aus_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  aus_pkg::cmd_t      cmd,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_kind,
  output logic [7:0]         out_byte_out,
  output logic [23:0]        out_unit_length,
  output logic [7:0]         out_slice_count,
  output logic               out_idr_seen,
  output logic               out_offset_valid,
  output logic signed [7:0]  out_first_offset,
  output logic [7:0]         out_pt_count,
  output logic               out_last
);

  localparam logic [aus_pkg::LENGTH_BITS-1:0] LEN_MAX = '1;

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

  function automatic aus_pkg::sei_t sei_feed(input aus_pkg::sei_t s, input logic [7:0] b,
                                             input logic [7:0] st);
    aus_pkg::sei_t n;
    n = s;
    if (s.phase != aus_pkg::SP_IDLE && s.phase != aus_pkg::SP_TYPE &&
        s.phase != aus_pkg::SP_SIZE) begin
      n.paid = sat16(s.paid, 8'd1);
    end
    case (s.phase)
      aus_pkg::SP_TYPE, aus_pkg::SP_SIZE: begin
        n.accum = sat16(s.accum, b);
        if (b != 8'hff) begin
          if (s.phase == aus_pkg::SP_TYPE) begin
            if (n.accum != {8'd0, st}) begin
              n.phase = aus_pkg::SP_IDLE;
            end else begin
              n.accum = 16'd0;
              n.phase = aus_pkg::SP_SIZE;
            end
          end else begin
            if (n.accum <= aus_pkg::SEI_SIZE_MIN) begin
              n.phase = aus_pkg::SP_IDLE;
            end else begin
              n.paid = 16'd0;
              n.phase = aus_pkg::SP_PAY0;
            end
          end
        end
      end
      aus_pkg::SP_PAY0: n.phase = b[7] ? aus_pkg::SP_IDLE : aus_pkg::SP_PAY1;
      aus_pkg::SP_PAY1: begin
        n.nest = 16'd0;
        n.phase = aus_pkg::SP_NEST;
      end
      aus_pkg::SP_NEST: begin
        n.nest = sat16(s.nest, b);
        if (b != 8'hff) begin
          if (n.nest <= aus_pkg::SEI_NEST_MIN) begin
            n.phase = aus_pkg::SP_IDLE;
          end else begin
            n.idx = 5'd0;
            n.target = 8'd0;
            n.ccount = 8'd0;
            n.cfirst = 8'd0;
            n.phase = aus_pkg::SP_HDR;
          end
        end
      end
      aus_pkg::SP_HDR: begin
        if (s.idx == aus_pkg::SEI_COUNT_POS) begin
          n.target = (b > aus_pkg::MAX_POINTS) ? aus_pkg::MAX_POINTS : b;
        end
        n.idx = s.idx + 5'd1;
        if (n.idx >= aus_pkg::SEI_HDR_LEN) begin
          n.phase = (n.target == 8'd0) ? aus_pkg::SP_DONE : aus_pkg::SP_POINTS;
        end
      end
      aus_pkg::SP_POINTS: begin
        if (s.ccount == 8'd0) begin
          n.cfirst = b[7] ? (8'd0 - {1'b0, b[6:0]}) : {1'b0, b[6:0]};
        end
        n.ccount = s.ccount + 8'd1;
        if (n.ccount >= s.target) begin
          n.phase = aus_pkg::SP_DONE;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  logic [2:0] k_r, k_nxt;
  logic drop_r, drop_nxt, open_r, open_nxt;
  logic [aus_pkg::LENGTH_BITS-1:0] ub_r, ub_nxt;
  logic [7:0] sl_r, sl_nxt;
  logic idr_r, idr_nxt;
  aus_pkg::sei_t sei_r, sei_nxt;
  logic ok_r, ok_nxt;
  logic [7:0] of_r, of_nxt, op_r, op_nxt;

  logic ov_r, ov_nxt;
  logic kind_r, kind_nxt, last_r, last_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic [23:0] ol_r, ol_nxt;
  logic [7:0] osl_r, osl_nxt, ofo_r, ofo_nxt, opc_r, opc_nxt;
  logic oidr_r, oidr_nxt, ook_r, ook_nxt;

  logic go, pay_en, body_en, sum_en, sum_last, done;
  logic sum_ok;
  logic [7:0] sum_of, sum_op;
  logic [7:0] pay_b;
  logic [4:0] t;

  assign t = cmd.data[4:0];
  assign out_empty = !ov_r;
  assign go = !q_empty && (!ov_r || out_pop);
  assign q_pop = go && done;

  always_comb begin
    k_nxt = k_r;
    drop_nxt = drop_r;
    open_nxt = open_r;
    ub_nxt = ub_r;
    sl_nxt = sl_r;
    idr_nxt = idr_r;
    sei_nxt = sei_r;
    ok_nxt = ok_r;
    of_nxt = of_r;
    op_nxt = op_r;
    sum_ok = ok_r;
    sum_of = of_r;
    sum_op = op_r;
    pay_en = 1'b0;
    body_en = 1'b0;
    pay_b = 8'd0;
    sum_en = 1'b0;
    sum_last = 1'b0;
    done = 1'b0;
    last_nxt = 1'b0;
    if (go) begin
      case (cmd.op)
        aus_pkg::OP_NORM: begin
          body_en = 1'b1;
          if (k_r < {1'b0, cmd.nzero}) begin
            k_nxt = k_r + 3'd1;
          end else begin
            pay_b = cmd.data;
            last_nxt = 1'b1;
            done = 1'b1;
          end
        end
        aus_pkg::OP_SC: begin
          if (sei_r.phase == aus_pkg::SP_DONE && sei_r.paid >= sei_r.nest && !ok_r) begin
            ok_nxt = 1'b1;
            of_nxt = sei_r.cfirst;
            op_nxt = sei_r.ccount;
          end
          sei_nxt = aus_pkg::SEI_IDLE;
          done = 1'b1;
        end
        aus_pkg::OP_HDR: begin
          case (k_r)
            3'd0: begin
              sei_nxt = aus_pkg::SEI_IDLE;
              if (t == cfg.drop_type) begin
                drop_nxt = 1'b1;
                done = 1'b1;
              end else begin
                drop_nxt = 1'b0;
                if ((t == cfg.delim_a || t == cfg.delim_b) && open_r) begin
                  sum_en = 1'b1;
                  k_nxt = 3'd1;
                end else begin
                  pay_en = 1'b1;
                  k_nxt = 3'd2;
                end
                if (t == cfg.delim_a || t == cfg.delim_b) begin
                  open_nxt = 1'b1;
                end
              end
            end
            3'd1, 3'd2, 3'd3: begin
              pay_en = 1'b1;
              k_nxt = k_r + 3'd1;
            end
            3'd4: begin
              pay_en = 1'b1;
              pay_b = 8'd1;
              k_nxt = 3'd5;
            end
            default: begin
              pay_en = 1'b1;
              pay_b = cmd.data;
              last_nxt = 1'b1;
              done = 1'b1;
              if ((t >= aus_pkg::NAL_SLICE_LO && t <= aus_pkg::NAL_IDR) ||
                  t == aus_pkg::NAL_SLICE_EXT) begin
                if (sl_r != 8'hff) begin
                  sl_nxt = sl_r + 8'd1;
                end
              end
              if (t == aus_pkg::NAL_IDR) begin
                idr_nxt = 1'b1;
              end
              if (t == aus_pkg::NAL_SEI) begin
                sei_nxt.phase = aus_pkg::SP_TYPE;
                sei_nxt.accum = 16'd0;
              end
            end
          endcase
        end
        aus_pkg::OP_EOS4: begin
          if (k_r == 3'd0) begin
            if (sei_r.phase == aus_pkg::SP_DONE && sei_r.paid >= sei_r.nest && !ok_r) begin
              ok_nxt = 1'b1;
              of_nxt = sei_r.cfirst;
              op_nxt = sei_r.ccount;
            end
            sei_nxt = aus_pkg::SEI_IDLE;
            drop_nxt = 1'b0;
          end
          if (k_r < 3'd4) begin
            pay_en = 1'b1;
            pay_b = (k_r == 3'd3) ? 8'd1 : 8'd0;
            k_nxt = k_r + 3'd1;
          end else begin
            sum_en = 1'b1;
            sum_last = 1'b1;
            done = 1'b1;
          end
        end
        default: begin
          if (k_r < {1'b0, cmd.nzero}) begin
            body_en = 1'b1;
            k_nxt = k_r + 3'd1;
          end else begin
            if (sei_r.phase == aus_pkg::SP_DONE && sei_r.paid >= sei_r.nest && !ok_r) begin
              ok_nxt = 1'b1;
              of_nxt = sei_r.cfirst;
              op_nxt = sei_r.ccount;
            end
            sum_en = (ub_r != '0);
            sum_last = 1'b1;
            done = 1'b1;
          end
        end
      endcase
      if (body_en) begin
        pay_en = !drop_r;
        if (!drop_r) begin
          sei_nxt = sei_feed(sei_r, pay_b, cfg.sei_code);
        end
      end
      if (pay_en && ub_r != LEN_MAX) begin
        ub_nxt = ub_r + 1'b1;
      end
      sum_ok = ok_nxt;
      sum_of = of_nxt;
      sum_op = op_nxt;
      if (cmd.op == aus_pkg::OP_HDR && sum_en) begin
        ub_nxt = '0;
        sl_nxt = 8'd0;
        idr_nxt = 1'b0;
        ok_nxt = 1'b0;
        of_nxt = 8'd0;
        op_nxt = 8'd0;
      end
      if (sum_last) begin
        drop_nxt = 1'b0;
        open_nxt = 1'b0;
        ub_nxt = '0;
        sl_nxt = 8'd0;
        idr_nxt = 1'b0;
        sei_nxt = aus_pkg::SEI_IDLE;
        ok_nxt = 1'b0;
        of_nxt = 8'd0;
        op_nxt = 8'd0;
      end
      if (done) begin
        k_nxt = 3'd0;
      end
    end
  end

  // output slot and unit bookkeeping that follows the emitted request
  always_comb begin
    ov_nxt = ov_r && !out_pop;
    kind_nxt = kind_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    osl_nxt = osl_r;
    oidr_nxt = oidr_r;
    ook_nxt = ook_r;
    ofo_nxt = ofo_r;
    opc_nxt = opc_r;
    if (pay_en || sum_en) begin
      ov_nxt = 1'b1;
      kind_nxt = sum_en;
      ob_nxt = sum_en ? 8'd0 : pay_b;
      ol_nxt = sum_en ? 24'(ub_r) : 24'd0;
      osl_nxt = sum_en ? sl_r : 8'd0;
      oidr_nxt = sum_en && idr_r;
      ook_nxt = sum_en && sum_ok;
      ofo_nxt = (sum_en && sum_ok) ? sum_of : 8'd0;
      opc_nxt = (sum_en && sum_ok) ? sum_op : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 3'd0;
      drop_r <= 1'b0;
      open_r <= 1'b0;
      ub_r <= '0;
      sl_r <= 8'd0;
      idr_r <= 1'b0;
      sei_r <= aus_pkg::SEI_IDLE;
      ok_r <= 1'b0;
      of_r <= 8'd0;
      op_r <= 8'd0;
      ov_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      drop_r <= drop_nxt;
      open_r <= open_nxt;
      ub_r <= ub_nxt;
      sl_r <= sl_nxt;
      idr_r <= idr_nxt;
      sei_r <= sei_nxt;
      ok_r <= ok_nxt;
      of_r <= of_nxt;
      op_r <= op_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    osl_r <= osl_nxt;
    oidr_r <= oidr_nxt;
    ook_r <= ook_nxt;
    ofo_r <= ofo_nxt;
    opc_r <= opc_nxt;
    if (pay_en || sum_en) begin
      last_r <= last_nxt || sum_last;
    end
  end

  assign out_kind = kind_r;
  assign out_byte_out = ob_r;
  assign out_unit_length = ol_r;
  assign out_slice_count = osl_r;
  assign out_idr_seen = oidr_r;
  assign out_offset_valid = ook_r;
  assign out_first_offset = signed'(ofo_r);
  assign out_pt_count = opc_r;
  assign out_last = last_r;

endmodule

FILE: sv/h264_access_unit_splitter_top.sv
// H.264 Annex B access unit splitter, top level
// An accepted byte's result passes the request queue, then the registered output slot.
// Throughput: one byte per cycle for ordinary payload while the output is popped; a held
// zero is emitted as its own byte. A NAL header becomes an optional summary plus a widened
// start code, absorbed by a 4-entry queue. End of stream flushes held bytes and a summary.
// Reset (rst_n low, synchronous) clears parse, unit and queue state and restores register defaults.
module h264_access_unit_splitter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_byte_in,
  input  logic               in_end_of_stream,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_kind,
  output logic [7:0]         out_byte_out,
  output logic [23:0]        out_unit_length,
  output logic [7:0]         out_slice_count,
  output logic               out_idr_seen,
  output logic               out_offset_valid,
  output logic signed [7:0]  out_first_offset,
  output logic [7:0]         out_pt_count,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  aus_pkg::cfg_t cfg_r;
  aus_pkg::cmd_t f_cmd, q_cmd;
  logic f_push, q_pop, q_empty, acc;

  assign cfg_ready = 1'b1;
  assign acc = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_type <= aus_pkg::DROP_RST;
      cfg_r.delim_a <= aus_pkg::DELA_RST;
      cfg_r.delim_b <= aus_pkg::DELB_RST;
      cfg_r.sei_code <= aus_pkg::SEI_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (aus_pkg::reg_idx_t'(cfg_index))
        aus_pkg::REG_DROP_TYPE: cfg_r.drop_type <= cfg_data[4:0];
        aus_pkg::REG_DELIM_A:   cfg_r.delim_a <= cfg_data[4:0];
        aus_pkg::REG_DELIM_B:   cfg_r.delim_b <= cfg_data[4:0];
        aus_pkg::REG_SEI_CODE:  cfg_r.sei_code <= cfg_data;
        default: ;
      endcase
    end
  end

  aus_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .byte_in  (in_byte_in),
    .eos      (in_end_of_stream),
    .cmd_push (f_push),
    .cmd      (f_cmd)
  );

  aus_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_cmd),
    .pop   (q_pop),
    .rdata (q_cmd),
    .full  (in_full),
    .empty (q_empty)
  );

  aus_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .cmd              (q_cmd),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_byte_out     (out_byte_out),
    .out_unit_length  (out_unit_length),
    .out_slice_count  (out_slice_count),
    .out_idr_seen     (out_idr_seen),
    .out_offset_valid (out_offset_valid),
    .out_first_offset (out_first_offset),
    .out_pt_count     (out_pt_count),
    .out_last         (out_last)
  );

endmodule
